### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NMEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NMEA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nmea_chk_pkg.sv
// ----------------------------------------------------------------------------
// nmea checksum checker package
// characters, verdict codes, result type and hex digit helper
// ----------------------------------------------------------------------------
package nmea_chk_pkg;

  localparam int unsigned LimitW = 7;

  localparam logic [7:0] CHAR_START   = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [LimitW-1:0] LIMIT_RESET = 7'd75;
  localparam logic [LimitW-1:0] POS_MAX     = 7'd127;

  localparam logic [2:0] V_OK       = 3'd0;
  localparam logic [2:0] V_NOSTART  = 3'd1;
  localparam logic [2:0] V_TOOLONG  = 3'd2;
  localparam logic [2:0] V_NOSEP    = 3'd3;
  localparam logic [2:0] V_MISMATCH = 3'd4;

  typedef struct packed {
    logic       line_ok;
    logic [2:0] verdict;
    logic [7:0] sum;
  } res_t;

  // uppercase ascii hex digit of a nibble
  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h37 + {4'h0, nib};
    end
    return r;
  endfunction

endpackage

### hdl/nmea_chk_scan.sv
// ----------------------------------------------------------------------------
// nmea checksum line scanner
// per-line state machine, running xor and verdict for one byte per cycle while step_i is high
// ----------------------------------------------------------------------------
module nmea_chk_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [7:0]                       byte_i,
  input  logic [nmea_chk_pkg::LimitW-1:0]  star_limit_i,
  output nmea_chk_pkg::res_t               res_o
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_SCAN  = 3'd1;
  localparam logic [2:0] PH_DIG1  = 3'd2;
  localparam logic [2:0] PH_DIG2  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  logic [2:0]                      phase_q, phase_d;
  logic [nmea_chk_pkg::LimitW-1:0] pos_q, pos_d;
  logic [7:0]                      xor_q, xor_d;
  logic                            hi_q, hi_d;
  logic [2:0]                      verdict_q, verdict_d;
  logic [2:0]                      end_verdict;

  // verdict if this byte ends the line
  always_comb begin
    case (phase_q)
      PH_START: end_verdict = nmea_chk_pkg::V_NOSTART;
      PH_SCAN: begin
        end_verdict = (pos_q >= star_limit_i) ? nmea_chk_pkg::V_TOOLONG
                                              : nmea_chk_pkg::V_NOSEP;
      end
      PH_DIG1, PH_DIG2: end_verdict = nmea_chk_pkg::V_MISMATCH;
      default: end_verdict = verdict_q;
    endcase
  end

  assign res_o.line_ok = (end_verdict == nmea_chk_pkg::V_OK);
  assign res_o.verdict = end_verdict;
  assign res_o.sum     = xor_q;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    xor_d     = xor_q;
    hi_d      = hi_q;
    verdict_d = verdict_q;
    if (byte_i == nmea_chk_pkg::CHAR_NEWLINE) begin
      phase_d   = PH_START;
      pos_d     = '0;
      xor_d     = '0;
      hi_d      = 1'b0;
      verdict_d = nmea_chk_pkg::V_OK;
    end else begin
      case (phase_q)
        PH_START: begin
          if (byte_i == nmea_chk_pkg::CHAR_START) begin
            phase_d = PH_SCAN;
            pos_d   = {{(nmea_chk_pkg::LimitW-1){1'b0}}, 1'b1};
          end else begin
            phase_d   = PH_DONE;
            verdict_d = nmea_chk_pkg::V_NOSTART;
          end
        end
        PH_SCAN: begin
          if (pos_q >= star_limit_i) begin
            phase_d   = PH_DONE;
            verdict_d = nmea_chk_pkg::V_TOOLONG;
          end else if (byte_i == 8'h00) begin
            phase_d   = PH_DONE;
            verdict_d = nmea_chk_pkg::V_NOSEP;
          end else if (byte_i == nmea_chk_pkg::CHAR_STAR) begin
            phase_d = PH_DIG1;
          end else begin
            xor_d = xor_q ^ byte_i;
            if (pos_q != nmea_chk_pkg::POS_MAX) begin
              pos_d = pos_q + {{(nmea_chk_pkg::LimitW-1){1'b0}}, 1'b1};
            end
          end
        end
        PH_DIG1: begin
          hi_d    = (byte_i == nmea_chk_pkg::hex_upper(xor_q[7:4]));
          phase_d = PH_DIG2;
        end
        PH_DIG2: begin
          phase_d = PH_DONE;
          if (hi_q && (byte_i == nmea_chk_pkg::hex_upper(xor_q[3:0]))) begin
            verdict_d = nmea_chk_pkg::V_OK;
          end else begin
            verdict_d = nmea_chk_pkg::V_MISMATCH;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      pos_q     <= '0;
      xor_q     <= '0;
      hi_q      <= 1'b0;
      verdict_q <= nmea_chk_pkg::V_OK;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      xor_q     <= xor_d;
      hi_q      <= hi_d;
      verdict_q <= verdict_d;
    end
  end

endmodule

### hdl/nmea_chk_out.sv
// ----------------------------------------------------------------------------
// nmea checksum result register
// holds one verdict until its transfer on the output channel
// ----------------------------------------------------------------------------
module nmea_chk_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  nmea_chk_pkg::res_t res_i,
  input  logic               ready_i,
  output logic               valid_o,
  output logic               free_o,
  output nmea_chk_pkg::res_t res_o
);

  logic               valid_q;
  nmea_chk_pkg::res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

### hdl/nmea_sentence_checksum_checker.sv
// a newline passes the input register and then the result register before its verdict shows on out_valid_o
// throughput: one byte per cycle unless a newline waits on a stalled output, set by the scan step and result register
// a stalled output holds a newline byte in the input register, which then takes no new byte; other bytes keep flowing
// reset: asynchronous, active low; line state cleared, star_limit back to 75
// ----------------------------------------------------------------------------
// nmea sentence checksum checker
// checks the xor checksum of received nmea lines, one verdict per newline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nmea_sentence_checksum_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nmea_chk_pkg::LimitW-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            line_ok_o,
  output logic [2:0]                      verdict_o,
  output logic [7:0]                      computed_sum_o
);

  logic [nmea_chk_pkg::LimitW-1:0] star_limit_q;
  logic                            in_valid_q;
  logic [7:0]                      byte_q;
  logic                            is_nl;
  logic                            out_free;
  logic                            advance;
  nmea_chk_pkg::res_t              scan_res;
  nmea_chk_pkg::res_t              out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      star_limit_q <= nmea_chk_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      star_limit_q <= cfg_wdata_i;
    end
  end

  assign is_nl      = (byte_q == nmea_chk_pkg::CHAR_NEWLINE);
  assign advance    = in_valid_q && (!is_nl || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  nmea_chk_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (byte_q),
    .star_limit_i (star_limit_q),
    .res_o        (scan_res)
  );

  nmea_chk_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && is_nl),
    .res_i   (scan_res),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .free_o  (out_free),
    .res_o   (out_res)
  );

  assign line_ok_o      = out_res.line_ok;
  assign verdict_o      = out_res.verdict;
  assign computed_sum_o = out_res.sum;

  `NMEA_ASSERT_NOW(a_ok_matches_verdict, out_valid_o, line_ok_o == (verdict_o == nmea_chk_pkg::V_OK), "line_ok disagrees with verdict")
  `NMEA_ASSERT_NOW(a_nostart_zero_sum, out_valid_o && (verdict_o == nmea_chk_pkg::V_NOSTART), computed_sum_o == 8'h00, "no start mark but nonzero sum")
  `NMEA_ASSERT_NXT(a_stall_holds_byte, in_valid_q && !advance, in_valid_q && $stable(byte_q), "stalled input byte lost")

endmodule
